[sv/bmhq_pkg.sv]
package bmhq_pkg;

	// Default sizing
	localparam int CAPACITY_DEF    = 127;
	localparam int VALUE_WIDTH_DEF = 32;

	// Port field widths
	localparam int IN_VALUE_W  = 32;
	localparam int RESULT_W    = 32;
	localparam int STATUS_W    = 2;
	localparam int COUNT_W     = 7;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	// Operation codes carried on the slave tuser
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EX_LOAD,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_DN_CHK,
		ST_DN_CMP,
		ST_PUSH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;     // item accepted this cycle
		logic ext_load;  // capture root and last element
		logic up_chk;    // sift-up: finish at root or read parent
		logic up_cmp;    // sift-up: compare with parent, move or settle
		logic dn_chk;    // sift-down: finish at leaf or read children
		logic dn_cmp;    // sift-down: compare with larger child, move or settle
		logic push;      // load result into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op_ext;
		logic full;
		logic empty;
		logic root;
		logic leaf;
		logic up_gt;
		logic dn_gt;
		logic out_free;
	} sts_t;

endpackage

[sv/binary_max_heap_queue.sv]
// Binary max-heap priority queue, one item in flight; each sift level costs a read then
// a compare and write. Insert sifts up from a new leaf; extract loads the root and last
// element, then sifts down; errors go straight to the push, which waits out output stalls.
// The next item is taken in the cycle after the push.
// Reset (arst_n, asynchronous, active low) empties the queue and the output register;
// the element store itself is not cleared.
module binary_max_heap_queue #(
	parameter int CAPACITY    = bmhq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [bmhq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // value
	input  logic                               s_axis_tuser,   // operation
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bmhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata    // result_value, status, count
);

	bmhq_pkg::cmd_t cmd;
	bmhq_pkg::sts_t sts;

	bmhq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	bmhq_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_op         (s_axis_tuser),
		.in_value      (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[sv/bmhq_ram.sv]
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

[sv/bmhq_dp.sv]
module bmhq_dp #(
	parameter int CAPACITY    = bmhq_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bmhq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bmhq_pkg::cmd_t                     cmd,
	output bmhq_pkg::sts_t                     sts,
	input  logic                               in_op,
	input  logic [bmhq_pkg::IN_VALUE_W-1:0]    in_value,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [bmhq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int AW  = $clog2(CAPACITY + 1);
	localparam int PAD = bmhq_pkg::OUT_TDATA_W - bmhq_pkg::RESULT_W
		- bmhq_pkg::STATUS_W - bmhq_pkg::COUNT_W;

	logic [AW-1:0]                      cnt_q;
	logic [AW-1:0]                      pos_q;
	logic [VALUE_WIDTH-1:0]             v_q;
	logic [bmhq_pkg::RESULT_W-1:0]      res_q;
	bmhq_pkg::status_t                  stat_q;
	logic                               out_valid_q;
	logic [bmhq_pkg::OUT_TDATA_W-1:0]   out_data_q;

	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [AW-1:0]          rd_addr_a;
	logic [AW-1:0]          rd_addr_b;
	logic [VALUE_WIDTH-1:0] rd_a;
	logic [VALUE_WIDTH-1:0] rd_b;

	logic [AW-1:0] parent;
	logic [AW:0]   child_l;
	logic [AW:0]   child_r;
	logic [AW:0]   cnt_ext;
	logic          r_ok;
	logic          pick_r;
	logic [VALUE_WIDTH-1:0] pick_val;
	logic [AW-1:0] pick_pos;
	logic          full;
	logic          empty;

	bmhq_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (CAPACITY + 1)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// Tree navigation and compares
	always_comb begin
		parent   = pos_q >> 1;
		child_l  = {pos_q, 1'b0};
		child_r  = {pos_q, 1'b1};
		cnt_ext  = {1'b0, cnt_q};
		r_ok     = child_r <= cnt_ext;
		pick_r   = r_ok && ($signed(rd_b) > $signed(rd_a));
		pick_val = pick_r ? rd_b : rd_a;
		pick_pos = pick_r ? child_r[AW-1:0] : child_l[AW-1:0];
		full     = cnt_q >= AW'(CAPACITY);
		empty    = cnt_q == '0;
	end

	always_comb begin
		sts.op_ext   = in_op == bmhq_pkg::OP_EXTRACT;
		sts.full     = full;
		sts.empty    = empty;
		sts.root     = pos_q == AW'(1);
		sts.leaf     = child_l > cnt_ext;
		sts.up_gt    = $signed(v_q) > $signed(rd_a);
		sts.dn_gt    = $signed(pick_val) > $signed(v_q);
		sts.out_free = !out_valid_q || m_axis_tready;
	end

	// Store port control; the moving element lives in v_q and is written once it settles
	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = v_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		if (cmd.start) begin
			rd_addr_a = AW'(1);
			rd_addr_b = cnt_q;
		end
		if (cmd.up_chk) begin
			if (sts.root) begin
				wr_en = 1'b1;
			end else begin
				rd_addr_a = parent;
			end
		end
		if (cmd.up_cmp) begin
			wr_en = 1'b1;
			if (sts.up_gt) begin
				wr_data = rd_a;
			end
		end
		if (cmd.dn_chk) begin
			if (sts.leaf) begin
				wr_en = 1'b1;
			end else begin
				rd_addr_a = child_l[AW-1:0];
				rd_addr_b = child_r[AW-1:0];
			end
		end
		if (cmd.dn_cmp) begin
			wr_en = 1'b1;
			if (sts.dn_gt) begin
				wr_data = pick_val;
			end
		end
	end

	// Element count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start && in_op == bmhq_pkg::OP_INSERT && !full) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (cmd.ext_load) begin
				cnt_q <= cnt_q - AW'(1);
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q <= '0;
			if (in_op == bmhq_pkg::OP_INSERT) begin
				stat_q <= full ? bmhq_pkg::STATUS_FULL : bmhq_pkg::STATUS_OK;
				pos_q  <= cnt_q + AW'(1);
				v_q    <= VALUE_WIDTH'($signed(in_value));
			end else begin
				stat_q <= empty ? bmhq_pkg::STATUS_EMPTY : bmhq_pkg::STATUS_OK;
			end
		end
		if (cmd.ext_load) begin
			res_q <= bmhq_pkg::RESULT_W'(rd_a);
			v_q   <= rd_b;
			pos_q <= AW'(1);
		end
		if (cmd.up_cmp && sts.up_gt) begin
			pos_q <= parent;
		end
		if (cmd.dn_cmp && sts.dn_gt) begin
			pos_q <= pick_pos;
		end
		if (cmd.push) begin
			out_data_q <= {{PAD{1'b0}}, bmhq_pkg::COUNT_W'(cnt_q), stat_q, res_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= AW'(CAPACITY))
		else $error("element count above capacity");

	a_no_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr != '0)
		else $error("write to unused slot zero");

	a_ext_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ext_load |=> cnt_q == $past(cnt_q) - AW'(1))
		else $error("extract did not decrement count");

endmodule

[sv/bmhq_ctrl.sv]
module bmhq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  bmhq_pkg::sts_t sts,
	output bmhq_pkg::cmd_t cmd
);

	bmhq_pkg::state_t state_q;
	bmhq_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		case (state_q)
			bmhq_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.start = 1'b1;
					if (sts.op_ext) begin
						state_d = sts.empty ? bmhq_pkg::ST_PUSH : bmhq_pkg::ST_EX_LOAD;
					end else begin
						state_d = sts.full ? bmhq_pkg::ST_PUSH : bmhq_pkg::ST_UP_CHK;
					end
				end
			end
			bmhq_pkg::ST_EX_LOAD: begin
				cmd.ext_load = 1'b1;
				state_d      = bmhq_pkg::ST_DN_CHK;
			end
			bmhq_pkg::ST_UP_CHK: begin
				cmd.up_chk = 1'b1;
				state_d    = sts.root ? bmhq_pkg::ST_PUSH : bmhq_pkg::ST_UP_CMP;
			end
			bmhq_pkg::ST_UP_CMP: begin
				cmd.up_cmp = 1'b1;
				state_d    = sts.up_gt ? bmhq_pkg::ST_UP_CHK : bmhq_pkg::ST_PUSH;
			end
			bmhq_pkg::ST_DN_CHK: begin
				cmd.dn_chk = 1'b1;
				state_d    = sts.leaf ? bmhq_pkg::ST_PUSH : bmhq_pkg::ST_DN_CMP;
			end
			bmhq_pkg::ST_DN_CMP: begin
				cmd.dn_cmp = 1'b1;
				state_d    = sts.dn_gt ? bmhq_pkg::ST_DN_CHK : bmhq_pkg::ST_PUSH;
			end
			bmhq_pkg::ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = bmhq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bmhq_pkg::ST_IDLE;
			end
		endcase
	end

	// Checks
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one command at once");

	a_push_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmhq_pkg::ST_PUSH && !sts.out_free) |=> state_q == bmhq_pkg::ST_PUSH)
		else $error("result dropped while output busy");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == bmhq_pkg::ST_IDLE)
		else $error("input taken outside idle");

endmodule
